/* hw/rtl/bpp_pkg.sv */
// Backend pick policy package: field widths, action, status, mode and state codes.
// No dependencies; used by bpp_mod and backend_pick_policy.
package bpp_pkg;

  localparam int unsigned ACT_W    = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned RND_W    = 31;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned IN_W     = 56;
  localparam int unsigned OUT_W    = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_PICK     = 2'd1,
    ACT_MARK_OFF = 2'd2,
    ACT_MARK_ON  = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_RR       = 2'd0,
    MODE_FIRST    = 2'd1,
    MODE_WEIGHTED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_FETCH,
    S_ACC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

endpackage

/* hw/rtl/backend_pick_policy.sv */
// Backend pick policy top level: backend table, pick sequencer, output register.
// Depends on bpp_pkg and bpp_mod.
//
// One item is handled at a time. Add and mark items go from dispatch to done. A
// round-robin or pick-first pick walks the availability bits one entry per cycle.
// A weighted pick walks the weight memory up to twice, a fetch and an accumulate
// state per entry (registered read), with the bit-serial remainder unit between.
// The block is ready again once the result is loaded into the output register;
// a waiting result stalls only the done state.
module backend_pick_policy #(
  parameter int unsigned MAX_BACKENDS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [3:0] backend_index, [19:4] weight, [50:20] random_value, [55:51] zero
  input  logic [bpp_pkg::IN_W-1:0]     s_axis_tdata,
  // [1:0] action
  input  logic [bpp_pkg::ACT_W-1:0]    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] status, [5:2] picked_index, [7:6] zero
  output logic [bpp_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bpp_pkg::MODE_W-1:0]   cfg_data
);
  import bpp_pkg::*;

  localparam int unsigned IW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int unsigned CW = $clog2(MAX_BACKENDS + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned TW = WEIGHT_W + CW;

  state_t               state, state_next;
  mode_t                mode;
  action_t              act;
  logic [IDX_W-1:0]     idx;
  logic [WEIGHT_W-1:0]  wgt;
  logic [RND_W-1:0]     rnd;
  logic [CW-1:0]        count, count_next;
  logic [IW-1:0]        rr, rr_next;
  logic [IW-1:0]        pos, pos_next;
  logic [CW-1:0]        n, n_next;
  logic [TW-1:0]        total, total_next;
  logic [TW-1:0]        sum, sum_next;
  logic [TW-1:0]        target, target_next;
  logic                 second, second_next;
  status_t              res_status, res_status_next;
  logic [IDX_W-1:0]     res_index, res_index_next;
  logic [MAX_BACKENDS-1:0] avail;
  logic [IDX_W-1:0]     res_index_q;
  status_t              res_status_q;

  logic                 av_we;
  logic [IW-1:0]        av_addr;
  logic                 av_val;
  logic                 wr_en;
  logic [WEIGHT_W-1:0]  rd_data;
  logic [WEIGHT_W-1:0]  wmem [MAX_BACKENDS];

  logic                 div_start;
  logic                 div_done;
  logic [TW-1:0]        div_rem;

  logic [XW-1:0]        idx_x;
  logic [XW-1:0]        count_x;
  logic [XW-1:0]        pos_x;
  logic [CW-1:0]        pos_inc;
  logic                 pos_last;
  logic [IW-1:0]        pos_wrap;
  logic [TW-1:0]        acc_w;
  logic                 out_free;

  assign idx_x    = XW'(idx);
  assign count_x  = XW'(count);
  assign pos_x    = XW'(pos);
  assign pos_inc  = CW'(pos) + 1'b1;
  assign pos_last = (pos_inc == count);
  assign pos_wrap = pos_last ? '0 : pos_inc[IW-1:0];
  assign acc_w    = TW'(rd_data);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {2'b00, res_index_q, res_status_q};

  bpp_mod #(.DW(TW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rnd),
    .divisor   (total),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    rr_next         = rr;
    pos_next        = pos;
    n_next          = n;
    total_next      = total;
    sum_next        = sum;
    target_next     = target;
    second_next     = second;
    res_status_next = res_status;
    res_index_next  = res_index;
    av_we           = 1'b0;
    av_addr         = pos;
    av_val          = 1'b0;
    wr_en           = 1'b0;
    div_start       = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_status_next = ST_NONE;
        res_index_next  = '0;
        state_next      = S_DONE;
        case (act)
          ACT_ADD: begin
            if (count >= CW'(MAX_BACKENDS)) begin
              res_status_next = ST_FULL;
            end else begin
              wr_en           = 1'b1;
              av_we           = 1'b1;
              av_addr         = count[IW-1:0];
              av_val          = 1'b1;
              res_status_next = ST_OK;
              res_index_next  = count_x[IDX_W-1:0];
              count_next      = count + 1'b1;
            end
          end
          ACT_PICK: begin
            n_next      = '0;
            total_next  = '0;
            sum_next    = '0;
            second_next = 1'b0;
            if (count != '0) begin
              case (mode)
                MODE_RR: begin
                  pos_next   = rr;
                  state_next = S_SCAN;
                end
                MODE_FIRST: begin
                  pos_next   = '0;
                  state_next = S_SCAN;
                end
                MODE_WEIGHTED: begin
                  pos_next   = '0;
                  state_next = S_FETCH;
                end
                default: begin
                  state_next = S_DONE;
                end
              endcase
            end
          end
          default: begin
            if (idx_x < count_x) begin
              av_we           = 1'b1;
              av_addr         = idx_x[IW-1:0];
              av_val          = (act == ACT_MARK_ON);
              res_status_next = ST_OK;
              res_index_next  = idx;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (avail[pos]) begin
          res_status_next = ST_OK;
          res_index_next  = pos_x[IDX_W-1:0];
          if (mode == MODE_RR) begin
            rr_next = pos_wrap;
          end
          state_next = S_DONE;
        end else begin
          n_next   = n + 1'b1;
          pos_next = pos_wrap;
          if (n + 1'b1 == count) begin
            state_next = S_DONE;
          end
        end
      end
      S_FETCH: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = S_FETCH;
        pos_next   = pos_wrap;
        if (!second) begin
          if (avail[pos]) begin
            total_next = total + acc_w;
          end
          if (pos_last) begin
            state_next = (total_next == '0) ? S_DONE : S_DIV_GO;
          end
        end else begin
          if (avail[pos]) begin
            sum_next = sum + acc_w;
          end
          if (avail[pos] && (sum_next > target)) begin
            res_status_next = ST_OK;
            res_index_next  = pos_x[IDX_W-1:0];
            state_next      = S_DONE;
          end else if (pos_last) begin
            state_next = S_DONE;
          end
        end
      end
      S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          target_next = div_rem;
          second_next = 1'b1;
          pos_next    = '0;
          state_next  = S_FETCH;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= MODE_RR;
      count         <= '0;
      rr            <= '0;
      avail         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rr    <= rr_next;
      if (cfg_valid) begin
        mode <= mode_t'(cfg_data);
      end
      if (av_we) begin
        avail[av_addr] <= av_val;
      end
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act <= action_t'(s_axis_tuser);
      idx <= s_axis_tdata[IDX_W-1:0];
      wgt <= s_axis_tdata[IDX_W +: WEIGHT_W];
      rnd <= s_axis_tdata[IDX_W+WEIGHT_W +: RND_W];
    end
    pos        <= pos_next;
    n          <= n_next;
    total      <= total_next;
    sum        <= sum_next;
    target     <= target_next;
    second     <= second_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    if (state == S_DONE && out_free) begin
      res_status_q <= res_status;
      res_index_q  <= res_index;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[count[IW-1:0]] <= (wgt == '0) ? WEIGHT_W'(1) : wgt;
    end
    rd_data <= wmem[pos];
  end

endmodule

/* hw/rtl/bpp_mod.sv */
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on bpp_pkg (RND_W).
module bpp_mod #(
  parameter int unsigned DW = 21
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bpp_pkg::RND_W-1:0] dividend,
  input  logic [DW-1:0]            divisor,
  output logic                     done,
  output logic [DW-1:0]            remainder
);
  import bpp_pkg::*;

  localparam int unsigned CNT_W = $clog2(RND_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RND_W-1:0] dvd;
  logic [DW-1:0]    rem;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  assign trial     = {rem, dvd[RND_W-1]};
  assign diff      = trial - {1'b0, divisor};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RND_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
    end
  end

endmodule

/* bench/backend_pick_policy_test.sv */
// Self-checking bench for backend_pick_policy: random-gap stream driver, stalling sink,
// in-bench table predictor and an in-order result check.
// Depends on bpp_pkg and the backend_pick_policy RTL.
module backend_pick_policy_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bpp_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    action_t              act;
    logic [IDX_W-1:0]     idx;
    logic [WEIGHT_W-1:0]  weight;
    logic [RND_W-1:0]     rnd;
  } request_t;

  typedef struct {
    status_t              status;
    logic [IDX_W-1:0]     picked;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic [ACT_W-1:0]   s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [MODE_W-1:0]  cfg_data = '0;

  backend_pick_policy #(
    .MAX_BACKENDS(TABLE_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted table state
  logic [WEIGHT_W-1:0] tbl_weight [TABLE_DEPTH];
  logic                tbl_avail  [TABLE_DEPTH];
  int unsigned         tbl_count = 0;
  int unsigned         rr_ptr = 0;
  logic [MODE_W-1:0]   mode_now = MODE_RR;

  request_t    requests_todo[$];
  answer_t     answers_due[$];
  request_t    on_bus;
  int unsigned added_so_far = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0, send_quiet = 0;
  int unsigned sink_hold = 0, sink_quiet = 0;

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_weight[i] = '0;
      tbl_avail[i]  = 1'b0;
    end
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int unsigned idle_len(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one accepted item to the predicted table and queues its answer.
  function automatic void resolve_request(input request_t r);
    answer_t     a;
    bit          found;
    int unsigned chosen, pos, total, target, sum;
    found  = 1'b0;
    chosen = 0;
    a.status = ST_NONE;
    a.picked = '0;
    case (r.act)
      ACT_ADD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          tbl_weight[tbl_count] = (r.weight == 0) ? WEIGHT_W'(1) : r.weight;
          tbl_avail[tbl_count]  = 1'b1;
          a.status = ST_OK;
          a.picked = tbl_count[IDX_W-1:0];
          tbl_count++;
        end
      end
      ACT_PICK: begin
        if (tbl_count != 0) begin
          case (mode_now)
            MODE_RR: begin
              pos = rr_ptr % tbl_count;
              for (int n = 0; n < tbl_count; n++) begin
                if (!found && tbl_avail[pos]) begin
                  found  = 1'b1;
                  chosen = pos;
                end
                pos = (pos + 1) % tbl_count;
              end
              if (found) rr_ptr = (chosen + 1) % tbl_count;
            end
            MODE_FIRST: begin
              for (int i = 0; i < tbl_count; i++) begin
                if (!found && tbl_avail[i]) begin
                  found  = 1'b1;
                  chosen = i;
                end
              end
            end
            MODE_WEIGHTED: begin
              total = 0;
              sum   = 0;
              for (int i = 0; i < tbl_count; i++)
                if (tbl_avail[i]) total += tbl_weight[i];
              if (total != 0) begin
                target = int'(r.rnd) % total;
                for (int i = 0; i < tbl_count; i++) begin
                  if (tbl_avail[i]) begin
                    sum += tbl_weight[i];
                    if (!found && sum > target) begin
                      found  = 1'b1;
                      chosen = i;
                    end
                  end
                end
              end
            end
            default: ;
          endcase
        end
        if (found) begin
          a.status = ST_OK;
          a.picked = chosen[IDX_W-1:0];
        end
      end
      default: begin
        if (r.idx < tbl_count) begin
          tbl_avail[r.idx] = (r.act == ACT_MARK_ON);
          a.status = ST_OK;
          a.picked = r.idx;
        end
      end
    endcase
    answers_due.push_back(a);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) resolve_request(on_bus);
      if (send_gap != 0 || requests_todo.size() == 0) begin
        if (send_gap != 0) send_gap--;
        s_axis_tvalid <= 1'b0;
      end else begin
        on_bus = requests_todo.pop_front();
        s_axis_tdata  <= {5'b0, on_bus.rnd, on_bus.weight, on_bus.idx};
        s_axis_tuser  <= on_bus.act;
        s_axis_tvalid <= 1'b1;
        send_gap = idle_len(send_quiet);
      end
    end
  end

  // sink backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold != 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 2) == 0) sink_hold = idle_len(sink_quiet);
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        $error("result with nothing expected: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
          mismatches++;
        end
        if (m_axis_tdata[5:2] !== want.picked) begin
          $error("picked_index: expected %0d, got %0d", want.picked, m_axis_tdata[5:2]);
          mismatches++;
        end
        if (m_axis_tdata[7:6] !== 2'b00) begin
          $error("pad: expected 0, got %0d", m_axis_tdata[7:6]);
          mismatches++;
        end
      end
    end
  end

  function automatic void queue_request(input action_t act, input int unsigned idx,
                                        input int unsigned w, input int unsigned rnd);
    request_t r;
    r.act    = act;
    r.idx    = idx[IDX_W-1:0];
    r.weight = w[WEIGHT_W-1:0];
    r.rnd    = rnd[RND_W-1:0];
    if (act == ACT_ADD) added_so_far++;
    requests_todo.push_back(r);
  endfunction

  // checked at the falling edge, after all rising-edge updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (requests_todo.size() != 0 || s_axis_tvalid || answers_due.size() != 0);
  endtask

  task automatic program_mode(input logic [MODE_W-1:0] m);
    wait_drained();
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    mode_now = m;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [MODE_W-1:0] m, input int unsigned n);
    int unsigned r, known, idx, w, rnd;
    action_t     act;
    program_mode(m);
    repeat (n) begin
      known = (added_so_far < TABLE_DEPTH) ? added_so_far : TABLE_DEPTH;
      r = $urandom_range(0, 99);
      if (r < 12)      act = ACT_ADD;
      else if (r < 55) act = ACT_PICK;
      else if (r < 72) act = ACT_MARK_OFF;
      else             act = ACT_MARK_ON;
      if (known == 0 || $urandom_range(0, 4) == 0) idx = $urandom_range(0, TABLE_DEPTH - 1);
      else idx = $urandom_range(0, known - 1);
      case ($urandom_range(0, 7))
        0:       w = 0;
        1:       w = 16'hFFFF;
        2:       w = $urandom_range(1, 4);
        default: w = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       rnd = 0;
        1:       rnd = 32'h7FFF_FFFF;
        default: rnd = $urandom;
      endcase
      queue_request(act, idx, w, rnd);
    end
  endtask

  initial begin
    logic [MODE_W-1:0] phase_modes [10];
    phase_modes = '{MODE_RR, MODE_FIRST, MODE_WEIGHTED, MODE_UNUSED, MODE_WEIGHTED,
                    MODE_RR, MODE_FIRST, MODE_WEIGHTED, MODE_RR, MODE_WEIGHTED};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, missing entries, zero and full-scale weights, round-robin wrap
    program_mode(MODE_RR);
    queue_request(ACT_PICK, 0, 0, 0);
    queue_request(ACT_MARK_ON, 0, 0, 0);
    queue_request(ACT_MARK_OFF, 15, 0, 0);
    queue_request(ACT_ADD, 0, 0, 0);
    queue_request(ACT_ADD, 0, 16'hFFFF, 0);
    queue_request(ACT_ADD, 0, 2, 0);
    repeat (4) queue_request(ACT_PICK, 0, 0, 0);
    queue_request(ACT_MARK_OFF, 1, 0, 0);
    repeat (2) queue_request(ACT_PICK, 0, 0, 0);
    queue_request(ACT_MARK_OFF, 0, 0, 0);
    queue_request(ACT_MARK_OFF, 2, 0, 0);
    queue_request(ACT_PICK, 0, 0, 0);
    queue_request(ACT_MARK_ON, 2, 0, 0);
    queue_request(ACT_MARK_ON, 3, 0, 0);
    program_mode(MODE_FIRST);
    queue_request(ACT_PICK, 0, 0, 0);
    queue_request(ACT_MARK_ON, 0, 0, 0);
    queue_request(ACT_PICK, 0, 0, 0);
    program_mode(MODE_WEIGHTED);
    queue_request(ACT_MARK_ON, 1, 0, 0);
    queue_request(ACT_PICK, 0, 0, 0);
    queue_request(ACT_PICK, 0, 0, 32'h7FFF_FFFF);
    queue_request(ACT_PICK, 0, 0, 1);
    program_mode(MODE_UNUSED);
    queue_request(ACT_PICK, 0, 0, 0);

    foreach (phase_modes[p]) random_phase(phase_modes[p], 60);

    // table full, top entry
    program_mode(MODE_RR);
    do queue_request(ACT_ADD, 0, $urandom, 0); while (added_so_far < TABLE_DEPTH + 2);
    queue_request(ACT_MARK_OFF, 15, 0, 0);
    queue_request(ACT_PICK, 0, 0, 0);
    queue_request(ACT_MARK_ON, 15, 0, 0);
    queue_request(ACT_PICK, 0, 0, 0);

    wait_drained();
    repeat (150) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bpp_pkg.sv
hw/rtl/bpp_mod.sv
hw/rtl/backend_pick_policy.sv
bench/backend_pick_policy_test.sv
